// ===== rtl/jrq_pkg.sv =====
// Shared types, widths and command codes of the reciprocal quantizer.
package jrq_pkg;

  localparam int unsigned WordW      = 16;
  localparam int unsigned ProdW      = 2 * WordW;
  localparam int unsigned PosW       = 6;
  // Wide enough to compare any position against up to 256 entries.
  localparam int unsigned PosExtW    = 9;
  localparam int unsigned TableW     = 3 * WordW;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned BlockEntriesDefault = 64;

  typedef enum logic {
    CmdLoad     = 1'b0,
    CmdQuantize = 1'b1
  } cmd_e;

  // One quantize request after the table read, as handed to the back end.
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [WordW-1:0] mag;
    logic [WordW-1:0] recip;
    logic [WordW-1:0] corr;
    logic [WordW-1:0] scale;
  } entry_t;

  typedef struct packed {
    logic valid;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic stage1_valid;
    logic out_valid;
  } back_stat_t;

endpackage

// ===== rtl/jrq_if.sv =====
// Request and response channel interfaces of the reciprocal quantizer.
interface jrq_in_if;
  import jrq_pkg::*;

  logic                    valid;
  logic                    ready;
  cmd_e                    command;
  logic [PosW-1:0]         position;
  logic signed [WordW-1:0] coefficient;
  logic [WordW-1:0]        reciprocal;
  logic [WordW-1:0]        correction;
  logic [WordW-1:0]        scale;

  modport source (
    output valid, command, position, coefficient, reciprocal, correction, scale,
    input  ready
  );
  modport sink (
    input  valid, command, position, coefficient, reciprocal, correction, scale,
    output ready
  );
endinterface

interface jrq_out_if;
  import jrq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] quantized;

  modport source (
    output valid, quantized,
    input  ready
  );
  modport sink (
    input  valid, quantized,
    output ready
  );
endinterface

// ===== rtl/jrq_front.sv =====
// Front end: accepts requests, writes the divisor tables, reads them for quantize requests.
module jrq_front #(
  parameter int unsigned BLOCK_ENTRIES = jrq_pkg::BlockEntriesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  jrq_in_if.sink                req_i,
  output jrq_pkg::entry_t       ent_o,
  output logic                  ent_valid_o,
  input  logic                  ent_ready_i,
  output jrq_pkg::front_stat_t  stat_o
);
  import jrq_pkg::*;

  localparam int unsigned IdxW = $clog2(BLOCK_ENTRIES);

  logic [TableW-1:0] mem_q [BLOCK_ENTRIES];
  logic [TableW-1:0] rd_q;

  logic              valid_q;
  logic              zero_q;
  logic              neg_q;
  logic [WordW-1:0]  mag_q;

  logic [PosExtW-1:0] pos_ext;
  logic [IdxW-1:0]    idx;
  logic               in_range;
  logic               ready;
  logic               accept;
  logic               do_load;
  logic               do_quant;
  logic               coef_neg;
  logic [WordW-1:0]   coef_u;
  logic [WordW-1:0]   coef_mag;

  assign pos_ext  = PosExtW'(req_i.position);
  assign in_range = pos_ext < PosExtW'(BLOCK_ENTRIES);
  assign idx      = pos_ext[IdxW-1:0];

  assign ready    = !valid_q || ent_ready_i;
  assign accept   = req_i.valid && ready;
  assign do_load  = accept && (req_i.command == CmdLoad);
  assign do_quant = accept && (req_i.command == CmdQuantize);

  // Magnitude read as unsigned, so the most negative value maps to 0x8000.
  assign coef_u   = req_i.coefficient;
  assign coef_neg = coef_u[WordW-1];
  assign coef_mag = coef_neg ? (~coef_u + WordW'(1)) : coef_u;

  always_ff @(posedge clk_i) begin
    if (do_load && in_range) begin
      mem_q[idx] <= {req_i.reciprocal, req_i.correction, req_i.scale};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_quant && in_range) begin
      rd_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_quant) begin
      zero_q <= (coef_u == '0) || !in_range;
      neg_q  <= coef_neg;
      mag_q  <= coef_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      // Loads leave nothing behind in this stage.
      valid_q <= do_quant;
    end
  end

  assign req_i.ready = ready;
  assign ent_valid_o = valid_q;

  always_comb begin
    ent_o       = '0;
    ent_o.zero  = zero_q;
    ent_o.neg   = neg_q;
    ent_o.mag   = mag_q;
    ent_o.recip = rd_q[TableW-1 -: WordW];
    ent_o.corr  = rd_q[2*WordW-1 -: WordW];
    ent_o.scale = rd_q[WordW-1:0];
  end

  assign stat_o.valid = valid_q;

endmodule

// ===== rtl/jrq_queue.sv =====
// Short request queue between front and back end.
module jrq_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jrq_pkg::entry_t      push_data_i,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  output jrq_pkg::entry_t      pop_data_o,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output jrq_pkg::queue_stat_t stat_o
);
  import jrq_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full;
  logic            empty;
  logic            push;
  logic            pop;

  assign full  = cnt_q == CntW'(QueueDepth);
  assign empty = cnt_q == '0;
  assign push  = push_valid_i && !full;
  assign pop   = pop_ready_i && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

endmodule

// ===== rtl/jrq_back.sv =====
// Back end: correction add, two high-half products, sign restore, output register.
module jrq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jrq_pkg::entry_t     ent_i,
  input  logic                ent_valid_i,
  output logic                ent_ready_o,
  jrq_out_if.source           rsp_o,
  output jrq_pkg::back_stat_t stat_o
);
  import jrq_pkg::*;

  logic             s1_valid_q;
  logic [WordW-1:0] s1_t_q;
  logic [WordW-1:0] s1_scale_q;
  logic             s1_neg_q;
  logic             s1_zero_q;

  logic             out_valid_q;
  logic [WordW-1:0] out_q;

  logic             s1_ready;
  logic             out_ready;
  logic [WordW-1:0] sum;
  logic [ProdW-1:0] prod1;
  logic [ProdW-1:0] prod2;
  logic [WordW-1:0] t2;
  logic [WordW-1:0] res;

  assign out_ready = !out_valid_q || rsp_o.ready;
  assign s1_ready  = !s1_valid_q || out_ready;

  // Correction add wraps to the word width.
  assign sum   = ent_i.mag + ent_i.corr;
  assign prod1 = {{WordW{1'b0}}, sum} * {{WordW{1'b0}}, ent_i.recip};

  assign prod2 = {{WordW{1'b0}}, s1_t_q} * {{WordW{1'b0}}, s1_scale_q};
  assign t2    = prod2[ProdW-1 -: WordW];

  always_comb begin
    if (s1_zero_q) begin
      res = '0;
    end else if (s1_neg_q) begin
      res = ~t2 + WordW'(1);
    end else begin
      res = t2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && ent_valid_i) begin
      s1_t_q     <= prod1[ProdW-1 -: WordW];
      s1_scale_q <= ent_i.scale;
      s1_neg_q   <= ent_i.neg;
      s1_zero_q  <= ent_i.zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= ent_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign ent_ready_o         = s1_ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.quantized     = out_q;
  assign stat_o.stage1_valid = s1_valid_q;
  assign stat_o.out_valid    = out_valid_q;

endmodule

// ===== rtl/jrq_reciprocal_quantizer.sv =====
// Top level of the reciprocal quantizer: front end, queue, back end.
//
//   channel  dir  payload                                                 request
//   req_i    in   command, position, coefficient, reciprocal, correction,  valid & ready
//                 scale
//   rsp_o    out  quantized                                               valid & ready
//
// One request per cycle sustained while the response is not stalled; a quantize result is
// registered at the table read, in the queue, after the first product and after the second product with sign restore.
// Loads write the tables at acceptance and give no response.
// Reset clears the stage valids and queue pointers; the tables are not cleared.
// A stalled response holds the output register; in a steady stream the front takes
// one more request in the first stalled cycle, then ready drops with five requests
// held (front stage, two queue slots, first product, output register).
module jpeg_reciprocal_quantizer #(
  parameter int unsigned BLOCK_ENTRIES = jrq_pkg::BlockEntriesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jrq_in_if.sink    req_i,
  jrq_out_if.source rsp_o
);
  import jrq_pkg::*;

  entry_t      front_ent;
  logic        front_valid;
  logic        front_ready;
  front_stat_t front_stat;

  entry_t      queue_ent;
  logic        queue_valid;
  logic        queue_ready;
  queue_stat_t queue_stat;

  back_stat_t  back_stat;

  jrq_front #(
    .BLOCK_ENTRIES (BLOCK_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ent_o       (front_ent),
    .ent_valid_o (front_valid),
    .ent_ready_i (front_ready),
    .stat_o      (front_stat)
  );

  jrq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_ent),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_ent),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .stat_o       (queue_stat)
  );

  jrq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (queue_ent),
    .ent_valid_i (queue_valid),
    .ent_ready_o (queue_ready),
    .rsp_o       (rsp_o),
    .stat_o      (back_stat)
  );

  // A load leaves the front stage empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.command == CmdLoad) |=> !front_stat.valid)
    else $error("load request left an entry in the front stage");

  // A request that is pushed and not popped leaves the queue non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_valid && front_ready && !(queue_valid && queue_ready)) |=> !queue_stat.empty)
    else $error("queue lost a pushed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(queue_stat.full && queue_stat.empty))
    else $error("queue reports full and empty at once");

  // A new response only comes out of the first back-end stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(back_stat.out_valid) |-> $past(back_stat.stage1_valid))
    else $error("response appeared without a request in the back end");

endmodule
